@@ rtl/core/two_sensor_people_counter_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Two-sensor people counter: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TWO_SENSOR_PEOPLE_COUNTER_UNIT_MACROS_SVH
`define TWO_SENSOR_PEOPLE_COUNTER_UNIT_MACROS_SVH

// same-cycle implication
`define TSPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error(msg);

// next-cycle implication
`define TSPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

@@ rtl/core/tspc_pkg.sv @@
// ----------------------------------------------------------------------------
// Two-sensor people counter: package
// Types, codes, constants and the echo width to distance conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tspc_pkg;

    localparam int CAPTURE_BITS = 16;

    typedef logic [CAPTURE_BITS-1:0] t_stamp;

    typedef enum logic [1:0] {
        CMD_CAPTURE_A = 2'd0,
        CMD_CAPTURE_B = 2'd1,
        CMD_EVALUATE  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ORDER_EMPTY = 2'd0,
        ORDER_A     = 2'd1,
        ORDER_B     = 2'd2
    } t_order;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_ENTRY = 2'd1,
        DIR_EXIT  = 2'd2
    } t_dir;

    typedef enum logic [0:0] {
        REG_NEAR_THRESHOLD = 1'd0,
        REG_TIMEOUT_LIMIT  = 1'd1
    } t_reg_idx;

    localparam logic [7:0]  NEAR_THRESHOLD_RST = 8'd50;
    localparam logic [15:0] TIMEOUT_LIMIT_RST  = 16'd200;
    localparam logic [15:0] COUNT_MAX          = 16'hFFFF;

    // distance = floor(2*width/125); saturates once width reaches 16000 us
    localparam logic [31:0] SAT_WIDTH = 32'(256 * 125 / 2);
    localparam int          DIV_SHIFT = 22;
    localparam logic [15:0] DIV_RECIP = 16'(((1 << DIV_SHIFT) + 124) / 125);

    typedef struct packed {
        logic [15:0] people_count;
        logic [7:0]  distance_a;
        logic [7:0]  distance_b;
        logic [1:0]  direction_event;
    } t_result;

    function automatic logic [7:0] echo_distance(input t_stamp rise, input t_stamp now);
        t_stamp      width;
        logic [31:0] w_ext;
        logic [14:0] twice;
        logic [31:0] prod;
        width = now - rise;
        if (now <= rise) begin
            width = width - t_stamp'(1);
        end
        w_ext = 32'(width);
        twice = {w_ext[13:0], 1'b0};
        prod  = 32'(twice) * 32'(DIV_RECIP);
        if (w_ext >= SAT_WIDTH) begin
            return 8'hFF;
        end
        return prod[DIV_SHIFT+7:DIV_SHIFT];
    endfunction

endpackage

@@ rtl/core/tspc_req_if.sv @@
// ----------------------------------------------------------------------------
// Two-sensor people counter: request channel
// Capture edges and evaluate ticks into the counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tspc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] capture_time;

    modport source (output valid, output command, output capture_time, input ready);
    modport sink   (input valid, input command, input capture_time, output ready);
endinterface

@@ rtl/core/tspc_res_if.sv @@
// ----------------------------------------------------------------------------
// Two-sensor people counter: result channel
// Count, last distances and direction event, one per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tspc_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] people_count;
    logic [7:0]  distance_a;
    logic [7:0]  distance_b;
    logic [1:0]  direction_event;

    modport source (output valid, output people_count, output distance_a,
                    output distance_b, output direction_event, input ready);
    modport sink   (input valid, input people_count, input distance_a,
                    input distance_b, input direction_event, output ready);
endinterface

@@ rtl/core/tspc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Two-sensor people counter: configuration write channel
// Register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tspc_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/two_sensor_people_counter_unit.sv @@
// ----------------------------------------------------------------------------
// Two-sensor people counter unit
// Bidirectional people counter from two ultrasonic echo channels.
// ----------------------------------------------------------------------------
// One result per request, one request per clock. Each request is decoded and
// its state update and result computed in the cycle it is accepted; the result
// goes to the output register, or to the skid entry if the output is stalled.
// The result side holds two entries (output register plus skid), so requests
// keep flowing while a result waits; ready drops only when both entries are
// full. The longest path is the echo width subtract and the reciprocal
// multiply of the distance conversion. Configuration writes are always taken.
`timescale 1ns / 1ps

`include "two_sensor_people_counter_unit_macros.svh"

module two_sensor_people_counter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tspc_req_if.sink   i_req,
    tspc_res_if.source o_res,
    tspc_cfg_if.sink   i_cfg
);
    import tspc_pkg::*;

    logic [7:0]  r_near_threshold;
    logic [15:0] r_timeout_limit;

    logic        r_waiting_a, n_waiting_a;
    t_stamp      r_rise_a,    n_rise_a;
    logic [7:0]  r_dist_a,    n_dist_a;
    logic        r_waiting_b, n_waiting_b;
    t_stamp      r_rise_b,    n_rise_b;
    logic [7:0]  r_dist_b,    n_dist_b;
    t_order      r_order,     n_order;
    logic [15:0] r_wait_ticks, n_wait_ticks;
    logic [15:0] r_occupancy,  n_occupancy;

    t_result     r_out, r_skid, n_result;
    logic        r_out_valid, r_skid_valid;

    t_stamp      now;
    t_order      second;
    t_dir        ev;
    logic        req_acc;
    logic        res_acc;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_skid_valid;
    assign req_acc     = i_req.valid && i_req.ready;
    assign res_acc     = r_out_valid && o_res.ready;

    always_comb begin
        n_waiting_a  = r_waiting_a;
        n_rise_a     = r_rise_a;
        n_dist_a     = r_dist_a;
        n_waiting_b  = r_waiting_b;
        n_rise_b     = r_rise_b;
        n_dist_b     = r_dist_b;
        n_order      = r_order;
        n_wait_ticks = r_wait_ticks;
        n_occupancy  = r_occupancy;
        second       = ORDER_EMPTY;
        ev           = DIR_NONE;
        now          = CAPTURE_BITS'(i_req.capture_time);

        case (t_cmd'(i_req.command))
            CMD_CAPTURE_A: begin
                if (!r_waiting_a) begin
                    n_rise_a = now;
                end else begin
                    n_dist_a = echo_distance(r_rise_a, now);
                end
                n_waiting_a = !r_waiting_a;
            end
            CMD_CAPTURE_B: begin
                if (!r_waiting_b) begin
                    n_rise_b = now;
                end else begin
                    n_dist_b = echo_distance(r_rise_b, now);
                end
                n_waiting_b = !r_waiting_b;
            end
            CMD_EVALUATE: begin
                if (r_dist_a < r_near_threshold && r_order != ORDER_A) begin
                    if (r_order == ORDER_EMPTY) begin
                        n_order = ORDER_A;
                    end else begin
                        second = ORDER_A;
                    end
                end else if (r_dist_b < r_near_threshold && r_order != ORDER_B) begin
                    if (r_order == ORDER_EMPTY) begin
                        n_order = ORDER_B;
                    end else begin
                        second = ORDER_B;
                    end
                end

                if (second == ORDER_B && n_order == ORDER_A) begin
                    if (r_occupancy != COUNT_MAX) begin
                        n_occupancy = r_occupancy + 16'd1;
                        ev          = DIR_ENTRY;
                    end
                    n_order = ORDER_EMPTY;
                end else if (second == ORDER_A && n_order == ORDER_B) begin
                    if (r_occupancy != 16'd0) begin
                        n_occupancy = r_occupancy - 16'd1;
                        ev          = DIR_EXIT;
                    end
                    n_order = ORDER_EMPTY;
                end

                if (r_wait_ticks > r_timeout_limit) begin
                    n_order      = ORDER_EMPTY;
                    n_wait_ticks = 16'd0;
                end else if (n_order != ORDER_EMPTY) begin
                    if (r_wait_ticks != COUNT_MAX) begin
                        n_wait_ticks = r_wait_ticks + 16'd1;
                    end
                end else begin
                    n_wait_ticks = 16'd0;
                end
            end
            default: begin
            end
        endcase

        n_result.people_count    = n_occupancy;
        n_result.distance_a      = n_dist_a;
        n_result.distance_b      = n_dist_b;
        n_result.direction_event = ev;
    end

    // state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_threshold <= NEAR_THRESHOLD_RST;
            r_timeout_limit  <= TIMEOUT_LIMIT_RST;
            r_waiting_a      <= 1'b0;
            r_rise_a         <= '0;
            r_dist_a         <= '0;
            r_waiting_b      <= 1'b0;
            r_rise_b         <= '0;
            r_dist_b         <= '0;
            r_order          <= ORDER_EMPTY;
            r_wait_ticks     <= '0;
            r_occupancy      <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (t_reg_idx'(i_cfg.index))
                    REG_NEAR_THRESHOLD: r_near_threshold <= i_cfg.data[7:0];
                    REG_TIMEOUT_LIMIT:  r_timeout_limit  <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            if (req_acc) begin
                r_waiting_a  <= n_waiting_a;
                r_rise_a     <= n_rise_a;
                r_dist_a     <= n_dist_a;
                r_waiting_b  <= n_waiting_b;
                r_rise_b     <= n_rise_b;
                r_dist_b     <= n_dist_b;
                r_order      <= n_order;
                r_wait_ticks <= n_wait_ticks;
                r_occupancy  <= n_occupancy;
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (res_acc) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (req_acc) begin
                if (r_out_valid && !o_res.ready) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (res_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (res_acc) begin
                r_out <= r_skid;
            end
        end else if (req_acc) begin
            if (r_out_valid && !o_res.ready) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.people_count    = r_out.people_count;
    assign o_res.distance_a      = r_out.distance_a;
    assign o_res.distance_b      = r_out.distance_b;
    assign o_res.direction_event = r_out.direction_event;

    `TSPC_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid full while output empty")
    `TSPC_ASSERT_IMP(a_idle_wait_clear, i_clk, i_rst_n, r_order == ORDER_EMPTY, r_wait_ticks == 16'd0, "wait ticks run with no pending sensor")
    `TSPC_ASSERT_NXT(a_count_on_eval, i_clk, i_rst_n, !(req_acc && i_req.command == CMD_EVALUATE), $stable(r_occupancy), "count moved outside an evaluate tick")

endmodule

@@ tb/two_sensor_people_counter_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Two-sensor people counter unit: testbench
// Drives capture edges and evaluate ticks through the request channel, with
// random gaps and back-pressure. Every request is predicted by a local model
// of the echo timing, the sensor ordering and the head count, and each
// response is compared field by field in order. It covers both register
// settings near their extremes and a long stall at the response side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_sensor_people_counter_unit_tb;
    import tspc_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 40000;
    localparam int         HOLD_LEN    = 150;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] stamp;
    } t_sense_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tspc_req_if req_ch ();
    tspc_res_if res_ch ();
    tspc_cfg_if cfg_ch ();

    two_sensor_people_counter_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // local copy of the counter state and registers
    logic [7:0]  near_lvl    = NEAR_THRESHOLD_RST;
    logic [15:0] timeout_lvl = TIMEOUT_LIMIT_RST;
    logic        armed [2]      = '{1'b0, 1'b0};
    logic [15:0] rise_stamp [2] = '{16'd0, 16'd0};
    logic [7:0]  range_cm [2]   = '{8'd0, 8'd0};
    t_order      order          = ORDER_EMPTY;
    logic [15:0] lone_ticks     = 16'd0;
    logic [15:0] headcount      = 16'd0;

    t_result     count_expected [$];
    t_sense_req  pending_reqs [$];

    int unsigned queued_total = 0;
    int unsigned err_cnt      = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned src_idle_pct = 28;
    int unsigned sink_idle_pct = 28;
    logic        req_taken    = 1'b0;
    logic        hold_flip    = 1'b0;
    logic        hold_seen    = 1'b0;
    int unsigned hold_left    = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] echo_to_cm(input logic [15:0] rise, input logic [15:0] now);
        logic [16:0] span;
        int unsigned cm;
        if (now > rise) begin
            span = {1'b0, now} - {1'b0, rise};
        end else begin
            span = 17'h0FFFF - {1'b0, rise} + {1'b0, now};
        end
        cm = (32'(span) * 2) / 125;
        return (cm > 255) ? 8'hFF : cm[7:0];
    endfunction

    function automatic t_result count_step(input logic [1:0] cmd, input logic [15:0] stamp);
        t_result     outcome;
        t_order      late_side;
        int unsigned s;
        outcome.direction_event = DIR_NONE;
        if (cmd == CMD_CAPTURE_A || cmd == CMD_CAPTURE_B) begin
            s = cmd[0];
            if (!armed[s]) begin
                rise_stamp[s] = stamp;
                armed[s] = 1'b1;
            end else begin
                range_cm[s] = echo_to_cm(rise_stamp[s], stamp);
                armed[s] = 1'b0;
            end
        end else if (cmd == CMD_EVALUATE) begin
            late_side = ORDER_EMPTY;
            if (range_cm[0] < near_lvl && order != ORDER_A) begin
                if (order == ORDER_EMPTY) order = ORDER_A;
                else late_side = ORDER_A;
            end else if (range_cm[1] < near_lvl && order != ORDER_B) begin
                if (order == ORDER_EMPTY) order = ORDER_B;
                else late_side = ORDER_B;
            end
            if (late_side == ORDER_B && order == ORDER_A) begin
                if (headcount != COUNT_MAX) begin
                    headcount++;
                    outcome.direction_event = DIR_ENTRY;
                end
                order = ORDER_EMPTY;
            end else if (late_side == ORDER_A && order == ORDER_B) begin
                if (headcount != 16'd0) begin
                    headcount--;
                    outcome.direction_event = DIR_EXIT;
                end
                order = ORDER_EMPTY;
            end
            if (lone_ticks > timeout_lvl) begin
                order = ORDER_EMPTY;
                lone_ticks = 16'd0;
            end else if (order != ORDER_EMPTY) begin
                if (lone_ticks != 16'hFFFF) lone_ticks++;
            end else begin
                lone_ticks = 16'd0;
            end
        end
        outcome.people_count = headcount;
        outcome.distance_a   = range_cm[0];
        outcome.distance_b   = range_cm[1];
        return outcome;
    endfunction

    // request side
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            count_expected.push_back(count_step(req_ch.command, req_ch.capture_time));
            req_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        t_sense_req nxt;
        if (!req_ch.valid || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = pending_reqs.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.command      <= nxt.command;
                req_ch.capture_time <= nxt.stamp;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    // response side back-pressure, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_flip != hold_seen) begin
            hold_seen = hold_flip;
            hold_left = HOLD_LEN;
        end
        if (hold_left != 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (count_expected.size() == 0) begin
                $display("%0t: response with none expected, count %0d", $time,
                         res_ch.people_count);
                err_cnt++;
            end else begin
                want = count_expected.pop_front();
                check_field("people_count", want.people_count, res_ch.people_count);
                check_field("distance_a", 16'(want.distance_a), 16'(res_ch.distance_a));
                check_field("distance_b", 16'(want.distance_b), 16'(res_ch.distance_b));
                check_field("direction_event", 16'(want.direction_event),
                            16'(res_ch.direction_event));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("two_sensor_people_counter_unit_tb: errors");
            $finish;
        end
    end

    // stimulus helpers; armed state tracked at queue time keeps echoes paired
    logic gen_open [2] = '{1'b0, 1'b0};

    task automatic add_req(input logic [1:0] cmd, input logic [15:0] stamp);
        pending_reqs.push_back('{cmd, stamp});
        queued_total++;
        if (cmd == CMD_CAPTURE_A || cmd == CMD_CAPTURE_B) gen_open[cmd[0]] = !gen_open[cmd[0]];
    endtask

    task automatic add_echo(input int unsigned s, input int unsigned width);
        logic [1:0]  cmd;
        logic [15:0] rise;
        cmd  = s ? CMD_CAPTURE_B : CMD_CAPTURE_A;
        rise = 16'($urandom);
        if (gen_open[s]) add_req(cmd, 16'($urandom));
        add_req(cmd, rise);
        add_req(cmd, rise + 16'(width));
    endtask

    function automatic int unsigned pick_width(input bit want_near);
        int unsigned cut_w;
        cut_w = (125 * int'(near_lvl) + 1) / 2;
        if (want_near && cut_w != 0) begin
            if ($urandom_range(7) == 0) return cut_w - 1;
            return $urandom_range(cut_w - 1, 0);
        end
        if (!want_near && $urandom_range(7) == 0) return cut_w;
        return $urandom_range(65535, want_near ? 0 : cut_w);
    endfunction

    task automatic add_tick();
        add_req(CMD_EVALUATE, 16'($urandom));
    endtask

    task automatic queue_traffic(input int unsigned n);
        int unsigned goal;
        int unsigned pick;
        int unsigned s;
        goal = queued_total + n;
        while (queued_total < goal) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                // walk in: outer then inner
                add_echo(0, pick_width(1));
                add_echo(1, pick_width(0));
                add_tick();
                if ($urandom_range(3) == 0) add_tick();
                add_echo(0, pick_width(0));
                add_echo(1, pick_width(1));
                add_tick();
            end else if (pick < 55) begin
                // walk out: inner then outer
                add_echo(0, pick_width(0));
                add_echo(1, pick_width(1));
                add_tick();
                if ($urandom_range(1) == 0) add_echo(1, pick_width(0));
                add_echo(0, pick_width(1));
                add_tick();
            end else if (pick < 70) begin
                add_echo($urandom_range(1), pick_width(1));
                repeat ($urandom_range(8, 1)) add_tick();
            end else if (pick < 85) begin
                s = $urandom_range(1);
                add_echo(s, pick_width($urandom_range(1)));
                add_tick();
            end else begin
                repeat ($urandom_range(3, 1)) add_req(2'($urandom_range(3)), 16'($urandom));
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_ch.valid || count_expected.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == REG_NEAR_THRESHOLD) near_lvl = val[7:0];
        else timeout_lvl = val;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.command      = CMD_CAPTURE_A;
        req_ch.capture_time = 16'd0;
        res_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_NEAR_THRESHOLD;
        cfg_ch.data         = 16'd0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset register values
        add_req(CMD_CAPTURE_A, 16'h0000);
        add_req(CMD_CAPTURE_A, 16'h0000);   // equal stamps, all-ones width
        add_req(CMD_EVALUATE,  16'hFFFF);   // inner first
        add_req(CMD_CAPTURE_A, 16'hFFFF);
        add_req(CMD_CAPTURE_A, 16'h0000);   // fall below rise
        add_req(CMD_EVALUATE,  16'h0000);   // exit with nobody inside
        add_req(CMD_EVALUATE,  16'h5555);
        add_req(CMD_EVALUATE,  16'hAAAA);   // entry
        add_req(CMD_CAPTURE_B, 16'h1234);
        add_req(CMD_CAPTURE_B, 16'h50B4);   // 16000 us, saturates
        add_req(CMD_EVALUATE,  16'h0001);
        add_req(CMD_CAPTURE_A, 16'h8000);
        add_req(CMD_CAPTURE_A, 16'h8C35);   // just at threshold
        add_req(CMD_UNUSED,    16'hFFFF);
        add_req(CMD_CAPTURE_B, 16'h00FF);
        add_req(CMD_CAPTURE_B, 16'h0D33);   // just below threshold
        add_req(CMD_EVALUATE,  16'h8000);   // entry
        add_req(CMD_EVALUATE,  16'h7FFF);
        add_req(CMD_CAPTURE_A, 16'hAAAA);
        add_req(CMD_CAPTURE_A, 16'hAAAB);
        add_req(CMD_EVALUATE,  16'h0F0F);   // exit
        add_req(CMD_CAPTURE_B, 16'hFFF0);
        add_req(CMD_CAPTURE_B, 16'h0010);
        add_req(CMD_UNUSED,    16'h0000);
        wait_idle();

        // sender flat out while the response side stalls
        write_reg(REG_NEAR_THRESHOLD, 16'd120);
        write_reg(REG_TIMEOUT_LIMIT, 16'd3);
        src_idle_pct = 0;
        queue_traffic(350);
        hold_flip = !hold_flip;
        wait_idle();

        write_reg(REG_NEAR_THRESHOLD, 16'd0);
        write_reg(REG_TIMEOUT_LIMIT, 16'd0);
        src_idle_pct = 28;
        queue_traffic(200);
        wait_idle();

        write_reg(REG_NEAR_THRESHOLD, 16'd255);
        write_reg(REG_TIMEOUT_LIMIT, 16'd65534);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        queue_traffic(250);
        wait_idle();

        write_reg(REG_NEAR_THRESHOLD, 16'd50);
        write_reg(REG_TIMEOUT_LIMIT, 16'd20);
        src_idle_pct  = 28;
        sink_idle_pct = 28;
        queue_traffic(275);
        wait_idle();
        queue_traffic(275);
        wait_idle();

        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("two_sensor_people_counter_unit_tb: clean");
        end else begin
            $display("two_sensor_people_counter_unit_tb: errors");
        end
        $finish;
    end

endmodule

@@ two_sensor_people_counter_unit.f @@
+incdir+rtl/core
rtl/core/tspc_pkg.sv
rtl/core/tspc_req_if.sv
rtl/core/tspc_res_if.sv
rtl/core/tspc_cfg_if.sv
rtl/core/two_sensor_people_counter_unit.sv
tb/two_sensor_people_counter_unit_tb.sv
